/* rtl/core/ptcc_pkg.sv */
// ----------------------------------------------------------------------------
// ptcc_pkg
// Shared types, constants and arithmetic helpers of the PLL clock and DRAM
// timing calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptcc_pkg;

  // Configuration port
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    RegRefClock       = 3'd0,
    RegRefreshInt     = 3'd1,
    RegRefreshCycle   = 3'd2,
    RegPostedRefresh  = 3'd3,
    RegCasLatency     = 3'd4
  } reg_idx_e;

  localparam logic [7:0]  RefClockRst     = 8'd24;
  localparam logic [15:0] RefreshIntRst   = 16'd7800;
  localparam logic [9:0]  RefreshCycleRst = 10'd162;
  localparam logic [3:0]  PostedRst       = 4'd8;
  localparam logic [5:0]  CasLatencyRst   = 6'd15;

  typedef struct packed {
    logic [7:0]  ref_clock_mhz;
    logic [15:0] refresh_interval_ns;
    logic [9:0]  refresh_cycle_ns;
    logic [3:0]  posted_refreshes;
    logic [5:0]  cas_latency_ns;
  } cfg_t;

  // Pipeline
  localparam int unsigned NumStages = 5;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctrl_t;

  // Field widths
  localparam int unsigned ClkW    = 15;
  localparam int unsigned RefiW   = 21;
  localparam int unsigned RfcW    = 15;
  localparam int unsigned ClW     = 11;
  localparam int unsigned WordW   = 32;
  localparam int unsigned RefiMulW = 31;
  localparam int unsigned RfcMulW  = 25;
  localparam int unsigned ClMulW   = 21;

  // Reciprocal constants: x/3 for x < 2^17 and x/1000 for x < 2^31.
  localparam int unsigned Div3Shift    = 17;
  localparam int unsigned Div3ProdW    = 32;
  localparam logic [15:0] Recip3       = 16'd43691;
  localparam int unsigned Div1kShift   = 41;
  localparam int unsigned Div1kProdW   = 63;
  localparam logic [31:0] Recip1000    = 32'd2199023256;

  // Packing constants
  localparam logic [WordW-1:0] PeriodOffset   = 32'd200;
  localparam logic [WordW-1:0] CasOffset      = 32'd4;
  localparam logic [WordW-1:0] RefreshEnable  = 32'h8000_0000;
  localparam logic [WordW-1:0] ModeFixedBits  = 32'h0000_0A00;

  // Divider select codes of the M field (value minus one).
  typedef enum logic [1:0] {
    MDiv1 = 2'd0,
    MDiv2 = 2'd1,
    MDiv3 = 2'd2,
    MDiv4 = 2'd3
  } m_sel_e;

  // ref * N * K of one PLL word.
  function automatic logic [ClkW-1:0] calc_prod(input logic [7:0]  ref_mhz,
                                                input logic [31:0] word);
    logic [12:0] rn;
    logic [2:0]  k;
    rn = 13'(ref_mhz) * 13'(word[12:8]);
    k  = 3'(word[5:4]) + 3'd1;
    return ClkW'(ClkW'(rn) * ClkW'(k));
  endfunction

  // Division by M in 1..4; the division by three is a reciprocal multiply.
  function automatic logic [ClkW-1:0] div_by_m(input logic [ClkW-1:0] x,
                                               input logic [1:0]      msel);
    logic [Div3ProdW-1:0] p;
    logic [ClkW-1:0]      q;
    p = Div3ProdW'(x) * Div3ProdW'(Recip3);
    unique case (m_sel_e'(msel))
      MDiv1:   q = x;
      MDiv2:   q = x >> 1;
      MDiv3:   q = p[Div3Shift +: ClkW];
      MDiv4:   q = x >> 2;
      default: q = x;
    endcase
    return q;
  endfunction

  // Truncating division by 1000 of a value below 2^31.
  function automatic logic [RefiW-1:0] div1000(input logic [RefiMulW-1:0] x);
    logic [Div1kProdW-1:0] p;
    p = Div1kProdW'(x) * Div1kProdW'(Recip1000);
    return p[Div1kShift +: RefiW];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ptcc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ptcc_cfg_regs
// APB register file holding the reference clock and DRAM timing settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcc_cfg_regs
  import ptcc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_clock_mhz       <= RefClockRst;
      cfg_q.refresh_interval_ns <= RefreshIntRst;
      cfg_q.refresh_cycle_ns    <= RefreshCycleRst;
      cfg_q.posted_refreshes    <= PostedRst;
      cfg_q.cas_latency_ns      <= CasLatencyRst;
    end else if (wr_en) begin
      unique case (idx)
        RegRefClock:      cfg_q.ref_clock_mhz       <= pwdata[7:0];
        RegRefreshInt:    cfg_q.refresh_interval_ns <= pwdata[15:0];
        RegRefreshCycle:  cfg_q.refresh_cycle_ns    <= pwdata[9:0];
        RegPostedRefresh: cfg_q.posted_refreshes    <= pwdata[3:0];
        RegCasLatency:    cfg_q.cas_latency_ns      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegRefClock:      prdata = DataW'(cfg_q.ref_clock_mhz);
      RegRefreshInt:    prdata = DataW'(cfg_q.refresh_interval_ns);
      RegRefreshCycle:  prdata = DataW'(cfg_q.refresh_cycle_ns);
      RegPostedRefresh: prdata = DataW'(cfg_q.posted_refreshes);
      RegCasLatency:    prdata = DataW'(cfg_q.cas_latency_ns);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/ptcc_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// ptcc_pipe_ctrl
// Valid bits and stage enables of the five-stage calculation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcc_pipe_ctrl
  import ptcc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output pipe_ctrl_t ctrl_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages:0]   ready;
  logic [NumStages-1:0] valid_in;

  // A stage takes a new request when it is empty or its contents move on.
  always_comb begin
    ready[NumStages] = ~out_stall_i;
    for (int i = NumStages - 1; i >= 0; i--) begin
      ready[i] = ~valid_q[i] | ready[i+1];
    end
  end

  always_comb begin
    valid_in = {valid_q[NumStages-2:0], in_valid_i};
    for (int i = 0; i < NumStages; i++) begin
      valid_d[i] = ready[i] ? valid_in[i] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.en   = ready[NumStages-1:0];
  assign in_stall_o  = ~ready[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

`default_nettype wire

/* rtl/core/ptcc_datapath.sv */
// ----------------------------------------------------------------------------
// ptcc_datapath
// Five register stages: products, divide by M (by P for the other clock), divide
// by P and tick multiplies, divide by 1000, and refresh period with word packing.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcc_datapath
  import ptcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire pipe_ctrl_t        ctrl_i,
  input  wire cfg_t              cfg_i,
  input  wire logic [WordW-1:0]  cpu_pll_word_i,
  input  wire logic [WordW-1:0]  dram_pll_word_i,
  output logic [ClkW-1:0]        cpu_clock_mhz_o,
  output logic [ClkW-1:0]        dram_clock_mhz_o,
  output logic [ClkW-1:0]        other_clock_mhz_o,
  output logic [RefiW-1:0]       refresh_interval_ticks_o,
  output logic [RfcW-1:0]        refresh_cycle_ticks_o,
  output logic [WordW-1:0]       refresh_period_ticks_o,
  output logic [ClW-1:0]         cas_ticks_o,
  output logic [WordW-1:0]       refresh_control_word_o,
  output logic [WordW-1:0]       mode_word_o
);

  // Stage 1
  logic [ClkW-1:0] s1_cprod_q, s1_dprod_q;
  logic [1:0]      s1_cm_q, s1_cp_q, s1_dm_q, s1_dp_q;
  // Stage 2
  logic [ClkW-1:0] s2_cdivm_q, s2_dclk_q, s2_oclk_q;
  logic [1:0]      s2_cp_q;
  // Stage 3
  logic [ClkW-1:0]     s3_cclk_q, s3_dclk_q, s3_oclk_q;
  logic [RefiMulW-1:0] s3_refi_q;
  logic [RfcMulW-1:0]  s3_rfc_q;
  logic [ClMulW-1:0]   s3_cl_q;
  // Stage 4
  logic [ClkW-1:0]  s4_cclk_q, s4_dclk_q, s4_oclk_q;
  logic [RefiW-1:0] s4_refi_q;
  logic [RfcW-1:0]  s4_rfc_q;
  logic [ClW-1:0]   s4_cl_q;
  // Stage 5
  logic [ClkW-1:0]  s5_cclk_q, s5_dclk_q, s5_oclk_q;
  logic [RefiW-1:0] s5_refi_q;
  logic [RfcW-1:0]  s5_rfc_q;
  logic [ClW-1:0]   s5_cl_q;
  logic [WordW-1:0] s5_prd_q, s5_drr_q, s5_mr_q;

  logic [RefiW-1:0] s4_refi_d;
  logic [WordW-1:0] s5_prd_d, s5_drr_d, s5_mr_d, cl_m4;
  logic [25:0]      refi_scaled;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      s1_cprod_q <= calc_prod(cfg_i.ref_clock_mhz, cpu_pll_word_i);
      s1_dprod_q <= calc_prod(cfg_i.ref_clock_mhz, dram_pll_word_i);
      s1_cm_q    <= cpu_pll_word_i[1:0];
      s1_cp_q    <= cpu_pll_word_i[17:16];
      s1_dm_q    <= dram_pll_word_i[1:0];
      s1_dp_q    <= dram_pll_word_i[17:16];
    end
  end

  // Dividing by M first and then by P gives the same floor as by M*P.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      s2_cdivm_q <= div_by_m(s1_cprod_q, s1_cm_q);
      s2_dclk_q  <= div_by_m(s1_dprod_q, s1_dm_q);
      s2_oclk_q  <= s1_dprod_q >> s1_dp_q;
      s2_cp_q    <= s1_cp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      s3_cclk_q <= s2_cdivm_q >> s2_cp_q;
      s3_dclk_q <= s2_dclk_q;
      s3_oclk_q <= s2_oclk_q;
      s3_refi_q <= RefiMulW'(cfg_i.refresh_interval_ns) * RefiMulW'(s2_dclk_q);
      s3_rfc_q  <= RfcMulW'(cfg_i.refresh_cycle_ns) * RfcMulW'(s2_dclk_q);
      s3_cl_q   <= ClMulW'(cfg_i.cas_latency_ns) * ClMulW'(s2_dclk_q);
    end
  end

  assign s4_refi_d = div1000(s3_refi_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      s4_cclk_q <= s3_cclk_q;
      s4_dclk_q <= s3_dclk_q;
      s4_oclk_q <= s3_oclk_q;
      s4_refi_q <= s4_refi_d;
      s4_rfc_q  <= RfcW'(div1000(RefiMulW'(s3_rfc_q)));
      s4_cl_q   <= ClW'(div1000(RefiMulW'(s3_cl_q)));
    end
  end

  // The period and the CAS offset wrap at 32 bits; shifted bits above
  // bit 31 are dropped when packed.
  always_comb begin
    refi_scaled = 26'(s4_refi_q) * 26'({1'b0, cfg_i.posted_refreshes} + 5'd1);
    s5_prd_d    = WordW'(refi_scaled) - PeriodOffset;
    s5_drr_d    = RefreshEnable
                | {4'b0, cfg_i.posted_refreshes, 24'b0}
                | {s5_prd_d[23:0], 8'b0}
                | WordW'(s4_rfc_q);
    cl_m4       = WordW'(s4_cl_q) - CasOffset;
    s5_mr_d     = {cl_m4[27:0], 4'b0} | ModeFixedBits;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      s5_cclk_q <= s4_cclk_q;
      s5_dclk_q <= s4_dclk_q;
      s5_oclk_q <= s4_oclk_q;
      s5_refi_q <= s4_refi_q;
      s5_rfc_q  <= s4_rfc_q;
      s5_cl_q   <= s4_cl_q;
      s5_prd_q  <= s5_prd_d;
      s5_drr_q  <= s5_drr_d;
      s5_mr_q   <= s5_mr_d;
    end
  end

  assign cpu_clock_mhz_o          = s5_cclk_q;
  assign dram_clock_mhz_o         = s5_dclk_q;
  assign other_clock_mhz_o        = s5_oclk_q;
  assign refresh_interval_ticks_o = s5_refi_q;
  assign refresh_cycle_ticks_o    = s5_rfc_q;
  assign refresh_period_ticks_o   = s5_prd_q;
  assign cas_ticks_o              = s5_cl_q;
  assign refresh_control_word_o   = s5_drr_q;
  assign mode_word_o              = s5_mr_q;

endmodule

`default_nettype wire

/* rtl/core/pll_clock_and_dram_timing_calc_core.sv */
// Pipeline: five register stages; a request accepted at the input raises
// out_valid_o once it reaches the last stage, and its result leaves when out_stall_i is low.
// Throughput: one request per cycle; the five register stages each take a
// new request whenever the stage after them moves on or is empty.
// The longest stage is the reciprocal multiply that divides by 1000.
// Reset: the pipeline empties and the configuration registers take their reset values.
// ----------------------------------------------------------------------------
// pll_clock_and_dram_timing_calc_core
// Computes PLL output clocks and DRAM refresh and CAS timing words.
// ----------------------------------------------------------------------------
`default_nettype none

module pll_clock_and_dram_timing_calc_core
  import ptcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic      [DataW-1:0]  prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [WordW-1:0]  cpu_pll_word_i,
  input  wire logic [WordW-1:0]  dram_pll_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ClkW-1:0]        cpu_clock_mhz_o,
  output logic [ClkW-1:0]        dram_clock_mhz_o,
  output logic [ClkW-1:0]        other_clock_mhz_o,
  output logic [RefiW-1:0]       refresh_interval_ticks_o,
  output logic [RfcW-1:0]        refresh_cycle_ticks_o,
  output logic [WordW-1:0]       refresh_period_ticks_o,
  output logic [ClW-1:0]         cas_ticks_o,
  output logic [WordW-1:0]       refresh_control_word_o,
  output logic [WordW-1:0]       mode_word_o
);

  cfg_t       cfg;
  pipe_ctrl_t ctrl;

  ptcc_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptcc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  ptcc_datapath u_dp (
    .clk_i                    (clk_i),
    .ctrl_i                   (ctrl),
    .cfg_i                    (cfg),
    .cpu_pll_word_i           (cpu_pll_word_i),
    .dram_pll_word_i          (dram_pll_word_i),
    .cpu_clock_mhz_o          (cpu_clock_mhz_o),
    .dram_clock_mhz_o         (dram_clock_mhz_o),
    .other_clock_mhz_o        (other_clock_mhz_o),
    .refresh_interval_ticks_o (refresh_interval_ticks_o),
    .refresh_cycle_ticks_o    (refresh_cycle_ticks_o),
    .refresh_period_ticks_o   (refresh_period_ticks_o),
    .cas_ticks_o              (cas_ticks_o),
    .refresh_control_word_o   (refresh_control_word_o),
    .mode_word_o              (mode_word_o)
  );

endmodule

`default_nettype wire

/* rtl/core/ptcc_checker.sv */
// ----------------------------------------------------------------------------
// ptcc_checker
// Port-level checks of the calculator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcc_checker
  import ptcc_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [ClkW-1:0]   cpu_clock_mhz_o,
  input wire logic [RfcW-1:0]   refresh_cycle_ticks_o,
  input wire logic [WordW-1:0]  refresh_control_word_o,
  input wire logic [WordW-1:0]  mode_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result was dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cpu_clock_mhz_o))
    else $error("stalled result changed");

  // The low byte of the control word holds the refresh cycle ticks alone.
  a_drr_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> refresh_control_word_o[31]
      && (refresh_control_word_o[7:0] == refresh_cycle_ticks_o[7:0]))
    else $error("refresh control word packed wrongly");

  a_mode_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mode_word_o[11] && mode_word_o[9]
      && (mode_word_o[3:0] == 4'b0000))
    else $error("mode word packed wrongly");

endmodule

bind pll_clock_and_dram_timing_calc_core ptcc_checker u_ptcc_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .cpu_clock_mhz_o        (cpu_clock_mhz_o),
  .refresh_cycle_ticks_o  (refresh_cycle_ticks_o),
  .refresh_control_word_o (refresh_control_word_o),
  .mode_word_o            (mode_word_o)
);

`default_nettype wire

/* dv/pll_clock_and_dram_timing_calc_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_clock_and_dram_timing_calc_core_test
// Streams pairs of PLL words through the timing calculator under several
// register settings and random handshake gaps, and checks every result field
// against a clock and DRAM timing predictor kept in this bench.
// ----------------------------------------------------------------------------
module pll_clock_and_dram_timing_calc_core_test;
  import ptcc_pkg::*;

  localparam int unsigned WdLimit     = 3000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned NumPhases   = 9;
  localparam int unsigned RandPerPhase = 148;
  localparam logic [2:0]  RegUnused   = 3'd5;
  localparam logic [31:0] FieldMask   = 32'h0003_1F33;

  typedef struct packed {
    logic [31:0] cpu;
    logic [31:0] dram;
  } pll_pair_t;

  typedef struct packed {
    logic [7:0]  ref_mhz;
    logic [15:0] interval_ns;
    logic [9:0]  cycle_ns;
    logic [3:0]  posted;
    logic [5:0]  cas_ns;
  } timing_cfg_t;

  typedef struct packed {
    logic [ClkW-1:0]  cpu_clk;
    logic [ClkW-1:0]  mem_clk;
    logic [ClkW-1:0]  other_clk;
    logic [RefiW-1:0] refi;
    logic [RfcW-1:0]  rfc;
    logic [WordW-1:0] period;
    logic [ClW-1:0]   cas;
    logic [WordW-1:0] ctrl;
    logic [WordW-1:0] mode;
  } timing_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_stall_o;
  logic [WordW-1:0] cpu_word = '0;
  logic [WordW-1:0] dram_word = '0;
  logic             out_valid_o;
  logic             out_stall = 1'b0;
  timing_t          got;

  pll_pair_t   pair_q[$];
  timing_t     timing_q[$];
  timing_cfg_t cfg_sh = '{RefClockRst, RefreshIntRst, RefreshCycleRst, PostedRst,
                          CasLatencyRst};
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;

  wire in_fire  = in_valid && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall;

  pll_clock_and_dram_timing_calc_core u_top (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready),
    .in_valid_i               (in_valid),
    .in_stall_o               (in_stall_o),
    .cpu_pll_word_i           (cpu_word),
    .dram_pll_word_i          (dram_word),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall),
    .cpu_clock_mhz_o          (got.cpu_clk),
    .dram_clock_mhz_o         (got.mem_clk),
    .other_clock_mhz_o        (got.other_clk),
    .refresh_interval_ticks_o (got.refi),
    .refresh_cycle_ticks_o    (got.rfc),
    .refresh_period_ticks_o   (got.period),
    .cas_ticks_o              (got.cas),
    .refresh_control_word_o   (got.ctrl),
    .mode_word_o              (got.mode)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Clocks and timing words for one pair of PLL words; 32-bit wrap as in the
  // block, truncated to the port widths at the end.
  function automatic timing_t calc_timing(input timing_cfg_t c, input logic [31:0] cw,
                                          input logic [31:0] dw);
    logic [31:0] cpu_prod, dram_prod, mem_clk, refi, rfc, period, cas;
    timing_t r;
    cpu_prod  = 32'(c.ref_mhz) * 32'(cw[12:8]) * (32'(cw[5:4]) + 32'd1);
    dram_prod = 32'(c.ref_mhz) * 32'(dw[12:8]) * (32'(dw[5:4]) + 32'd1);
    mem_clk   = dram_prod / (32'(dw[1:0]) + 32'd1);
    refi      = (32'(c.interval_ns) * mem_clk) / 32'd1000;
    rfc       = (32'(c.cycle_ns) * mem_clk) / 32'd1000;
    cas       = (32'(c.cas_ns) * mem_clk) / 32'd1000;
    period    = refi * (32'(c.posted) + 32'd1) - 32'd200;
    r.cpu_clk   = ClkW'(cpu_prod / ((32'(cw[1:0]) + 32'd1) << cw[17:16]));
    r.mem_clk   = ClkW'(mem_clk);
    r.other_clk = ClkW'(dram_prod >> dw[17:16]);
    r.refi      = RefiW'(refi);
    r.rfc       = RfcW'(rfc);
    r.period    = period;
    r.cas       = ClW'(cas);
    r.ctrl      = 32'h8000_0000 | (32'(c.posted) << 24) | (period << 8) | rfc;
    r.mode      = ((cas - 32'd4) << 4) | (32'd5 << 9);
    return r;
  endfunction

  function automatic logic [31:0] pll_word(input logic [1:0] m, input logic [1:0] k,
                                           input logic [4:0] n, input logic [1:0] p,
                                           input logic [31:0] junk);
    return (junk & ~FieldMask) | {14'd0, p, 3'd0, n, 2'd0, k, 2'd0, m};
  endfunction

  function automatic logic [31:0] reg_value(input reg_idx_e idx);
    case (idx)
      RegRefClock:      return 32'(cfg_sh.ref_mhz);
      RegRefreshInt:    return 32'(cfg_sh.interval_ns);
      RegRefreshCycle:  return 32'(cfg_sh.cycle_ns);
      RegPostedRefresh: return 32'(cfg_sh.posted);
      RegCasLatency:    return 32'(cfg_sh.cas_ns);
      default:          return 32'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] val,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, val, want);
    fail_cnt++;
  endtask

  task automatic cmp_field(input string what, input logic [31:0] val,
                           input logic [31:0] want);
    if (val !== want) begin
      report_mismatch(what, val, want);
    end
  endtask

  // Writes a register; bits above its width carry random junk half the time.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] junk;
    junk = $urandom_range(1) ? $urandom : 32'd0;
    case (idx)
      RegRefClock: begin
        cfg_sh.ref_mhz = val[7:0];
        val = {junk[31:8], val[7:0]};
      end
      RegRefreshInt: begin
        cfg_sh.interval_ns = val[15:0];
        val = {junk[31:16], val[15:0]};
      end
      RegRefreshCycle: begin
        cfg_sh.cycle_ns = val[9:0];
        val = {junk[31:10], val[9:0]};
      end
      RegPostedRefresh: begin
        cfg_sh.posted = val[3:0];
        val = {junk[31:4], val[3:0]};
      end
      RegCasLatency: begin
        cfg_sh.cas_ns = val[5:0];
        val = {junk[31:6], val[5:0]};
      end
      default: begin
      end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_regs();
    reg_idx_e idx;
    idx = idx.first();
    do begin
      @(posedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= AddrW'({idx, 2'b00});
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      cmp_field($sformatf("register %s", idx.name()), prdata, reg_value(idx));
      psel    <= 1'b0;
      penable <= 1'b0;
      idx = idx.next();
    end while (idx != idx.first());
  endtask

  task automatic set_cfg(input logic [31:0] ref_v, input logic [31:0] int_v,
                         input logic [31:0] cyc_v, input logic [31:0] post_v,
                         input logic [31:0] cas_v);
    write_reg(RegRefClock, ref_v);
    write_reg(RegRefreshInt, int_v);
    write_reg(RegRefreshCycle, cyc_v);
    write_reg(RegPostedRefresh, post_v);
    write_reg(RegCasLatency, cas_v);
  endtask

  // A register value at one of its extremes half the time.
  function automatic logic [31:0] pick_val(input int unsigned hi);
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return hi;
      default: return $urandom_range(hi);
    endcase
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    pll_pair_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        timing_q.push_back(calc_timing(cfg_sh, cpu_word, dram_word));
      end
      if (!in_valid || !in_stall_o) begin
        if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pair_q.pop_front();
          cpu_word  <= nxt.cpu;
          dram_word <= nxt.dram;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once by the sequence.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_left <= HoldCycles;
      hold_seen <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    timing_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        if (timing_q.size() == 0) begin
          report_mismatch("result with no request pending", 32'd0, 32'd0);
        end else begin
          want = timing_q.pop_front();
          cmp_field("cpu_clock_mhz", 32'(got.cpu_clk), 32'(want.cpu_clk));
          cmp_field("dram_clock_mhz", 32'(got.mem_clk), 32'(want.mem_clk));
          cmp_field("other_clock_mhz", 32'(got.other_clk), 32'(want.other_clk));
          cmp_field("refresh_interval_ticks", 32'(got.refi), 32'(want.refi));
          cmp_field("refresh_cycle_ticks", 32'(got.rfc), 32'(want.rfc));
          cmp_field("refresh_period_ticks", got.period, want.period);
          cmp_field("cas_ticks", 32'(got.cas), 32'(want.cas));
          cmp_field("refresh_control_word", got.ctrl, want.ctrl);
          cmp_field("mode_word", got.mode, want.mode);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WdLimit) begin
      $display("pll_clock_and_dram_timing_calc_core_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : seq_proc
    logic [3:0] sel;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph / 3)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0: begin
        end
        1: set_cfg(32'd255, 32'd65535, 32'd1023, 32'd15, 32'd63);
        3: begin
          set_cfg(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
          write_reg(RegUnused, $urandom);
        end
        5: set_cfg($urandom_range(255), $urandom_range(60, 1), $urandom_range(1023),
                   $urandom_range(15), $urandom_range(63));
        7: set_cfg(32'd24, 32'd7800, 32'd162, 32'd0, 32'd15);
        8: set_cfg(32'd255, pick_val(65535), pick_val(1023), $urandom_range(15, 9), 32'd1);
        default: set_cfg(pick_val(255), pick_val(65535), pick_val(1023), pick_val(15),
                         pick_val(63));
      endcase
      check_regs();
      @(negedge clk_i);
      if (ph == 0) begin
        // Zero words, all-ones words, then every M, K and P select on both
        // words with the bits outside the fields set on some of them.
        pair_q.push_back('{32'd0, 32'd0});
        pair_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        for (int i = 0; i < 16; i++) begin
          sel = 4'(i);
          pair_q.push_back('{pll_word(sel[1:0], sel[3:2], 5'd31, sel[3:2], 32'd0),
                             pll_word(sel[3:2], sel[1:0], 5'(31 - i), sel[1:0],
                                      sel[0] ? 32'hFFFF_FFFF : 32'd0)});
        end
        pair_q.push_back('{pll_word(2'd0, 2'd0, 5'd1, 2'd0, 32'd0),
                           pll_word(2'd0, 2'd0, 5'd1, 2'd3, 32'hFFFF_FFFF)});
      end
      for (int i = 0; i < RandPerPhase; i++) begin
        if ($urandom_range(3) == 0) begin
          pair_q.push_back('{$urandom,
                             pll_word(2'($urandom), 2'($urandom), 5'($urandom_range(3)),
                                      2'($urandom), $urandom)});
        end else begin
          pair_q.push_back('{$urandom, $urandom});
        end
      end
      if (ph == 6) begin
        hold_req = 1'b1;
      end
      while (pair_q.size() != 0 || in_valid || timing_q.size() != 0) begin
        @(negedge clk_i);
      end
      repeat (DrainCycles) @(posedge clk_i);
    end
    if (fail_cnt == 0) begin
      $display("pll_clock_and_dram_timing_calc_core_test: PASS");
    end else begin
      $display("pll_clock_and_dram_timing_calc_core_test: FAIL");
    end
    $finish;
  end

endmodule
